FILE: rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on the rising clock edge, masked while reset is low
`define S2R_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// concurrent check on the rising clock edge, also active during reset
`define S2R_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/s2r_pkg.sv
// shared types, constants and helper functions of the spo2 ratio estimator
package s2r_pkg;

  localparam int NUM_SENSORS = 2;
  localparam int SAMPLE_BITS = 22;
  localparam int SEL_W       = 1;
  localparam int CNT_W       = 16;
  localparam int SKIP_W      = 8;
  localparam int CAL_W       = 16;
  localparam int CAL_FRAC    = 8;
  localparam int RQ_W        = 16;
  localparam int FRAC_BITS   = 12;
  localparam int INT_SHIFT   = RQ_W - FRAC_BITS;
  localparam int SPO2_W      = 8;
  localparam int SPO2_SHIFT  = CAL_FRAC + FRAC_BITS;
  localparam int DIFF_W      = 2 * CAL_W + 1;
  localparam int MUL_W       = (SAMPLE_BITS > CAL_W) ? SAMPLE_BITS : CAL_W;
  localparam int PROD_W      = 2 * MUL_W;
  localparam int MCNT_W      = $clog2(MUL_W + 1);
  localparam int DCNT_W      = $clog2(RQ_W + 1);
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CNT_W-1:0]  WIN_LEN_RST = 16'd256;
  localparam logic [SKIP_W-1:0] SKIP_RST    = 8'd16;
  localparam logic [CAL_W-1:0]  SLOPE_RST   = 16'd998;
  localparam logic [CAL_W-1:0]  ICPT_RST    = 16'd25779;

  localparam logic [CFG_IDX_W-1:0] REG_WIN_LEN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SKIP    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLOPE   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ICPT    = 2'd3;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  typedef logic signed [SAMPLE_BITS-1:0] smp_t;
  typedef logic [SAMPLE_BITS-1:0]        mag_t;
  typedef logic [MUL_W-1:0]              mul_t;
  typedef logic [PROD_W-1:0]             prod_t;

  // channel update request from the input handshake
  typedef struct packed {
    logic             clr;
    logic             smp;
    logic [SEL_W-1:0] sel;
  } upd_t;

  // (hi + lo) / 2 rounded toward zero
  function automatic smp_t half_sum(smp_t hi, smp_t lo);
    logic signed [SAMPLE_BITS:0] s;
    s = (SAMPLE_BITS + 1)'(hi) + (SAMPLE_BITS + 1)'(lo);
    if (s[SAMPLE_BITS]) begin
      s = s + (SAMPLE_BITS + 1)'(1);
    end
    return smp_t'(s >>> 1);
  endfunction

  function automatic mag_t mag_of(smp_t v);
    return v[SAMPLE_BITS-1] ? mag_t'(-v) : mag_t'(v);
  endfunction

endpackage

FILE: rtl/s2r_chan.sv
// per-sensor min/max tracking, skip and window counters
module s2r_chan import s2r_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  upd_t              upd,
  input  smp_t              red,
  input  smp_t              ir,
  input  logic [CNT_W-1:0]  win_len,
  input  logic [SKIP_W-1:0] skip_cfg,
  input  logic [SEL_W-1:0]  rd_sel,
  output logic              win_done,
  output smp_t              red_max,
  output smp_t              red_min,
  output smp_t              ir_max,
  output smp_t              ir_min
);

  smp_t              red_max_r [NUM_SENSORS];
  smp_t              red_min_r [NUM_SENSORS];
  smp_t              ir_max_r  [NUM_SENSORS];
  smp_t              ir_min_r  [NUM_SENSORS];
  logic [CNT_W-1:0]  cnt_r     [NUM_SENSORS];
  logic [SKIP_W-1:0] skip_r    [NUM_SENSORS];

  smp_t              red_max_nxt, red_min_nxt, ir_max_nxt, ir_min_nxt;
  logic [CNT_W-1:0]  cnt_inc, cnt_nxt, wl;
  logic [SKIP_W-1:0] skip_nxt;
  logic              first;

  always_comb begin
    first = (cnt_r[upd.sel] == '0);
    red_max_nxt = red_max_r[upd.sel];
    red_min_nxt = red_min_r[upd.sel];
    ir_max_nxt  = ir_max_r[upd.sel];
    ir_min_nxt  = ir_min_r[upd.sel];
    if (first) begin
      red_max_nxt = red;
      red_min_nxt = red;
      ir_max_nxt  = ir;
      ir_min_nxt  = ir;
    end else begin
      // a new max leaves the min alone
      if (red_max_r[upd.sel] < red) begin
        red_max_nxt = red;
      end else if (red_min_r[upd.sel] > red) begin
        red_min_nxt = red;
      end
      if (ir_max_r[upd.sel] < ir) begin
        ir_max_nxt = ir;
      end else if (ir_min_r[upd.sel] > ir) begin
        ir_min_nxt = ir;
      end
    end
    if (skip_r[upd.sel] == '0) begin
      cnt_inc  = cnt_r[upd.sel] + CNT_W'(1);
      skip_nxt = skip_r[upd.sel];
    end else begin
      cnt_inc  = cnt_r[upd.sel];
      skip_nxt = skip_r[upd.sel] - SKIP_W'(1);
    end
    wl = (win_len == '0) ? CNT_W'(1) : win_len;
    win_done = upd.smp && (cnt_inc >= wl);
    cnt_nxt = win_done ? '0 : cnt_inc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NUM_SENSORS; s++) begin
        red_max_r[s] <= '0;
        red_min_r[s] <= '0;
        ir_max_r[s]  <= '0;
        ir_min_r[s]  <= '0;
        cnt_r[s]     <= '0;
        skip_r[s]    <= SKIP_RST;
      end
    end else if (upd.clr) begin
      red_max_r[upd.sel] <= '0;
      red_min_r[upd.sel] <= '0;
      ir_max_r[upd.sel]  <= '0;
      ir_min_r[upd.sel]  <= '0;
      cnt_r[upd.sel]     <= '0;
      skip_r[upd.sel]    <= skip_cfg;
    end else if (upd.smp) begin
      red_max_r[upd.sel] <= red_max_nxt;
      red_min_r[upd.sel] <= red_min_nxt;
      ir_max_r[upd.sel]  <= ir_max_nxt;
      ir_min_r[upd.sel]  <= ir_min_nxt;
      cnt_r[upd.sel]     <= cnt_nxt;
      skip_r[upd.sel]    <= skip_nxt;
    end
  end

  assign red_max = red_max_r[rd_sel];
  assign red_min = red_min_r[rd_sel];
  assign ir_max  = ir_max_r[rd_sel];
  assign ir_min  = ir_min_r[rd_sel];

endmodule

FILE: rtl/s2r_mul.sv
// bit-serial shift-add multiplier, one multiplier bit per cycle
module s2r_mul import s2r_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  mul_t  a,
  input  mul_t  b,
  output prod_t p,
  output logic  done
);

  mul_t              a_r;
  prod_t             p_r;
  logic [MCNT_W-1:0] cnt_r;
  logic              done_r;
  logic [MUL_W:0]    sum;

  // upper half accumulates, lower half shifts the multiplier out
  assign sum = {1'b0, p_r[PROD_W-1:MUL_W]} + (p_r[0] ? {1'b0, a_r} : '0);

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      p_r <= {MUL_W'(0), b};
    end else if (cnt_r != '0) begin
      p_r <= {sum, p_r[MUL_W-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= !start && (cnt_r == MCNT_W'(1));
      if (start) begin
        cnt_r <= MCNT_W'(MUL_W);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - MCNT_W'(1);
      end
    end
  end

  assign p    = p_r;
  assign done = done_r;

endmodule

FILE: rtl/s2r_div.sv
// restoring divider, one quotient bit per cycle, saturating Q4.12 result
module s2r_div import s2r_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  prod_t           num,
  input  prod_t           den,
  output logic [RQ_W-1:0] q,
  output logic            done
);

  prod_t             r_r, den_r, hi;
  logic [RQ_W-1:0]   nb_r, q_r;
  logic [DCNT_W-1:0] cnt_r;
  logic              done_r, sat, ge;
  logic [PROD_W:0]   trial, diff;

  assign hi    = num >> INT_SHIFT;
  assign sat   = (hi >= den);
  assign trial = {r_r, nb_r[RQ_W-1]};
  assign ge    = (trial >= {1'b0, den_r});
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= den;
      r_r   <= hi;
      // low numerator bits then the fraction zeros
      nb_r  <= {num[INT_SHIFT-1:0], FRAC_BITS'(0)};
      q_r   <= sat ? '1 : '0;
    end else if (cnt_r != '0) begin
      r_r  <= ge ? diff[PROD_W-1:0] : trial[PROD_W-1:0];
      nb_r <= {nb_r[RQ_W-2:0], 1'b0};
      q_r  <= {q_r[RQ_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      if (start) begin
        cnt_r  <= sat ? '0 : DCNT_W'(RQ_W);
        done_r <= sat;
      end else begin
        done_r <= (cnt_r == DCNT_W'(1));
        if (cnt_r != '0) begin
          cnt_r <= cnt_r - DCNT_W'(1);
        end
      end
    end
  end

  assign q    = q_r;
  assign done = done_r;

endmodule

FILE: rtl/spo2_window_ratio_estimator.sv
// Windowed SpO2 ratio-of-ratios estimator, top level. After the sample that
// closes a window, no item is taken until that window's result reaches the
// output register. The two products acR*|dcIR| and |dcR|*acIR run on
// bit-serial shift-add multipliers at one bit a cycle. The Q4.12 ratio comes
// from a restoring divider at one quotient bit a cycle. The calibration
// product slope*R reuses the first multiplier. A saturated ratio skips the
// divider steps. A flagged window goes from the check state straight to the
// done state, past the multipliers and the divider. A finished result sits in
// the output register, so the block takes the next item while the result
// waits to be taken. A second finished result holds the input until the
// first one is taken.
module spo2_window_ratio_estimator import s2r_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_command,
  input  logic [SEL_W-1:0]      in_sensor_select,
  input  smp_t                  in_red_sample,
  input  smp_t                  in_ir_sample,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [SEL_W-1:0]      out_sensor_id,
  output logic [SPO2_W-1:0]     out_spo2,
  output logic [RQ_W-1:0]       out_ratio_q12,
  output mag_t                  out_red_ac,
  output smp_t                  out_red_dc,
  output mag_t                  out_ir_ac,
  output smp_t                  out_ir_dc,
  output logic                  out_ratio_error,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CALC  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_SPO2  = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  win_len_r;
  logic [SKIP_W-1:0] skip_cfg_r;
  logic [CAL_W-1:0]  slope_r, icpt_r;

  logic [SEL_W-1:0]  sel_r;
  mag_t              red_ac_r, ir_ac_r;
  smp_t              red_dc_r, ir_dc_r;
  logic              err_r;
  logic [RQ_W-1:0]   rq_r;
  logic [SPO2_W-1:0] spo2_r;

  logic              out_valid_r;
  logic [SEL_W-1:0]  out_sel_r;
  logic [SPO2_W-1:0] out_spo2_r;
  logic [RQ_W-1:0]   out_rq_r;
  mag_t              out_red_ac_r, out_ir_ac_r;
  smp_t              out_red_dc_r, out_ir_dc_r;
  logic              out_err_r;

  upd_t              upd;
  logic              acc, sel_ok, win_done, err, load_out;
  smp_t              red_max, red_min, ir_max, ir_min;
  logic              mul0_start, mul1_start, mul0_done, mul1_done;
  mul_t              mul0_a, mul0_b, mul1_a, mul1_b;
  prod_t             p0, p1;
  logic              div_start, div_done;
  logic [RQ_W-1:0]   div_q;
  logic [DIFF_W-1:0] diff;
  logic [DIFF_W-SPO2_SHIFT-2:0] spo2_int;
  logic [SPO2_W-1:0] spo2_val;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_len_r  <= WIN_LEN_RST;
      skip_cfg_r <= SKIP_RST;
      slope_r    <= SLOPE_RST;
      icpt_r     <= ICPT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_WIN_LEN: win_len_r  <= cfg_data[CNT_W-1:0];
        REG_SKIP:    skip_cfg_r <= cfg_data[SKIP_W-1:0];
        REG_SLOPE:   slope_r    <= cfg_data[CAL_W-1:0];
        REG_ICPT:    icpt_r     <= cfg_data[CAL_W-1:0];
      endcase
    end
  end

  // input side
  assign in_ready = (state_r == S_IDLE);
  assign acc      = in_valid && in_ready;
  assign sel_ok   = (32'(in_sensor_select) < NUM_SENSORS);
  assign upd.clr  = acc && sel_ok && (in_command == CMD_CLEAR);
  assign upd.smp  = acc && sel_ok && (in_command == CMD_SAMPLE);
  assign upd.sel  = in_sensor_select;

  s2r_chan u_chan (
    .clk      (clk),
    .rst_n    (rst_n),
    .upd      (upd),
    .red      (in_red_sample),
    .ir       (in_ir_sample),
    .win_len  (win_len_r),
    .skip_cfg (skip_cfg_r),
    .rd_sel   (sel_r),
    .win_done (win_done),
    .red_max  (red_max),
    .red_min  (red_min),
    .ir_max   (ir_max),
    .ir_min   (ir_min)
  );

  // zero denominator, or a negative ratio with a nonzero numerator
  assign err = (red_dc_r == '0) || (ir_dc_r == '0) || (ir_ac_r == '0) ||
               ((red_ac_r != '0) && (red_dc_r[SAMPLE_BITS-1] != ir_dc_r[SAMPLE_BITS-1]));

  // first multiplier is shared with the calibration product
  assign mul0_start = ((state_r == S_CHECK) && !err) || ((state_r == S_DIV) && div_done);
  assign mul1_start = (state_r == S_CHECK) && !err;
  assign mul0_a = (state_r == S_CHECK) ? MUL_W'(red_ac_r) : MUL_W'(slope_r);
  assign mul0_b = (state_r == S_CHECK) ? MUL_W'(mag_of(ir_dc_r)) : MUL_W'(div_q);
  assign mul1_a = MUL_W'(mag_of(red_dc_r));
  assign mul1_b = MUL_W'(ir_ac_r);

  s2r_mul u_mul0 (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul0_start),
    .a     (mul0_a),
    .b     (mul0_b),
    .p     (p0),
    .done  (mul0_done)
  );

  s2r_mul u_mul1 (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul1_start),
    .a     (mul1_a),
    .b     (mul1_b),
    .p     (p1),
    .done  (mul1_done)
  );

  assign div_start = (state_r == S_MUL) && mul0_done && mul1_done;

  s2r_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (p0),
    .den   (p1),
    .q     (div_q),
    .done  (div_done)
  );

  // intercept in Q8.20 minus slope*R, integer part clamped to 0..255
  assign diff = DIFF_W'({icpt_r, FRAC_BITS'(0)}) - DIFF_W'(p0[2*CAL_W-1:0]);
  assign spo2_int = diff[DIFF_W-2:SPO2_SHIFT];

  always_comb begin
    if (diff[DIFF_W-1]) begin
      spo2_val = '0;
    end else if (spo2_int > (DIFF_W-SPO2_SHIFT-1)'({SPO2_W{1'b1}})) begin
      spo2_val = '1;
    end else begin
      spo2_val = spo2_int[SPO2_W-1:0];
    end
  end

  assign load_out = (state_r == S_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (win_done) state_nxt = S_CALC;
      S_CALC:  state_nxt = S_CHECK;
      S_CHECK: state_nxt = err ? S_DONE : S_MUL;
      S_MUL:   if (div_start) state_nxt = S_DIV;
      S_DIV:   if (div_done) state_nxt = S_SPO2;
      S_SPO2:  if (mul0_done) state_nxt = S_DONE;
      S_DONE:  if (load_out) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // working registers of the window result
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && win_done) begin
      sel_r <= in_sensor_select;
    end
    if (state_r == S_CALC) begin
      red_ac_r <= mag_t'(red_max - red_min);
      ir_ac_r  <= mag_t'(ir_max - ir_min);
      red_dc_r <= half_sum(red_max, red_min);
      ir_dc_r  <= half_sum(ir_max, ir_min);
    end
    if (state_r == S_CHECK) begin
      err_r <= err;
      if (err) begin
        rq_r   <= '0;
        spo2_r <= '0;
      end
    end
    if (state_r == S_DIV && div_done) begin
      rq_r <= div_q;
    end
    if (state_r == S_SPO2 && mul0_done) begin
      spo2_r <= spo2_val;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_sel_r    <= sel_r;
      out_spo2_r   <= spo2_r;
      out_rq_r     <= rq_r;
      out_red_ac_r <= red_ac_r;
      out_red_dc_r <= red_dc_r;
      out_ir_ac_r  <= ir_ac_r;
      out_ir_dc_r  <= ir_dc_r;
      out_err_r    <= err_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_sensor_id   = out_sel_r;
  assign out_spo2        = out_spo2_r;
  assign out_ratio_q12   = out_rq_r;
  assign out_red_ac      = out_red_ac_r;
  assign out_red_dc      = out_red_dc_r;
  assign out_ir_ac       = out_ir_ac_r;
  assign out_ir_dc       = out_ir_dc_r;
  assign out_ratio_error = out_err_r;

endmodule

FILE: rtl/s2r_checker.sv
// port-level checks of the estimator and their bind to the top level
`include "assert_macros.svh"

module s2r_checker import s2r_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              in_command,
  input logic              out_valid,
  input logic              out_ready,
  input logic [SPO2_W-1:0] out_spo2,
  input logic [RQ_W-1:0]   out_ratio_q12,
  input logic              out_ratio_error,
  input logic              cfg_ready
);

  logic out_wait, clr_take, err_out, zero_out;

  assign out_wait = out_valid && !out_ready;
  assign clr_take = in_valid && in_ready && (in_command == CMD_CLEAR);
  assign err_out  = out_valid && out_ratio_error;
  assign zero_out = (out_spo2 == '0) && (out_ratio_q12 == '0);

  // a result not taken stays offered
  `S2R_ASSERT(a_out_hold, clk, rst_n, out_wait |=> out_valid, "result item dropped")

  // a clear item never stalls the input
  `S2R_ASSERT(a_clear_fast, clk, rst_n, clr_take |=> in_ready, "input stalled after clear")

  // an error result carries zero ratio and zero spo2
  `S2R_ASSERT(a_err_zero, clk, rst_n, err_out |-> zero_out, "error result with nonzero outputs")

  // the input reopens as soon as a result is posted
  `S2R_ASSERT(a_reopen, clk, rst_n, $rose(out_valid) |-> in_ready, "input closed while result waits")

  // configuration writes are always taken
  `S2R_ASSERT_ALWAYS(a_cfg_ready, clk, cfg_ready, "config port not ready")

endmodule

bind spo2_window_ratio_estimator s2r_checker u_s2r_checker (.*);

FILE: bench/spo2_window_ratio_estimator_tb.sv
// self-checking bench for the windowed spo2 ratio-of-ratios estimator
`timescale 1ns / 100ps

module spo2_window_ratio_estimator_tb;
  import s2r_pkg::*;

  localparam int N_PHASES    = 8;
  localparam int PRESS_PHASE = 1;
  localparam int PRESS_HOLD  = 300;
  localparam int QUIET_LIMIT = 3000;
  localparam int SETTLE_CYC  = 100;

  typedef struct {
    logic             cmd;
    logic [SEL_W-1:0] sel;
    smp_t             red;
    smp_t             ir;
    int unsigned      gap;
  } sample_item_t;

  typedef struct {
    logic [SEL_W-1:0]  id;
    logic [SPO2_W-1:0] spo2;
    logic [RQ_W-1:0]   rq;
    mag_t              rac;
    smp_t              rdc;
    mag_t              iac;
    smp_t              idc;
    logic              err;
  } window_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_command = CMD_SAMPLE;
  logic [SEL_W-1:0]      in_sensor_select = '0;
  smp_t                  in_red_sample = '0;
  smp_t                  in_ir_sample = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [SEL_W-1:0]      out_sensor_id;
  logic [SPO2_W-1:0]     out_spo2;
  logic [RQ_W-1:0]       out_ratio_q12;
  mag_t                  out_red_ac;
  smp_t                  out_red_dc;
  mag_t                  out_ir_ac;
  smp_t                  out_ir_dc;
  logic                  out_ratio_error;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_WIN_LEN;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  spo2_window_ratio_estimator u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_sensor_select (in_sensor_select),
    .in_red_sample    (in_red_sample),
    .in_ir_sample     (in_ir_sample),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_sensor_id    (out_sensor_id),
    .out_spo2         (out_spo2),
    .out_ratio_q12    (out_ratio_q12),
    .out_red_ac       (out_red_ac),
    .out_red_dc       (out_red_dc),
    .out_ir_ac        (out_ir_ac),
    .out_ir_dc        (out_ir_dc),
    .out_ratio_error  (out_ratio_error),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #5 clk = ~clk;

  // shadow copy of the registers and the per-channel window trackers
  logic [CNT_W-1:0]  win_len   = WIN_LEN_RST;
  logic [SKIP_W-1:0] skip_load = SKIP_RST;
  logic [CAL_W-1:0]  slope_cal = SLOPE_RST;
  logic [CAL_W-1:0]  icpt_cal  = ICPT_RST;
  smp_t              red_lo [NUM_SENSORS];
  smp_t              red_hi [NUM_SENSORS];
  smp_t              ir_lo [NUM_SENSORS];
  smp_t              ir_hi [NUM_SENSORS];
  logic [CNT_W-1:0]  win_count [NUM_SENSORS];
  logic [SKIP_W-1:0] skip_left [NUM_SENSORS];

  sample_item_t   sample_fifo[$];
  window_result_t window_results[$];

  int miss_count   = 0;
  int items_taken  = 0;
  int clears_taken = 0;
  int windows_seen = 0;
  int flagged_seen = 0;
  int sat_seen     = 0;
  int reg_writes   = 0;
  int queued_total = 0;
  int press_token  = 0;
  int quiet_cycles = 0;

  // synthetic pulse shape per sensor for well-formed traffic
  int dc_r [NUM_SENSORS];
  int dc_i [NUM_SENSORS];
  int amp_r [NUM_SENSORS];
  int amp_i [NUM_SENSORS];
  int pulse_left [NUM_SENSORS];

  initial begin
    for (int s = 0; s < NUM_SENSORS; s++) begin
      red_lo[s] = '0;
      red_hi[s] = '0;
      ir_lo[s] = '0;
      ir_hi[s] = '0;
      win_count[s] = '0;
      skip_left[s] = SKIP_RST;
      pulse_left[s] = 0;
    end
  end

  task automatic log_miss(input string what, input logic [63:0] want, input logic [63:0] got);
    miss_count++;
    $display("[%0t] %s: expected %0h, got %0h", $time, what, want, got);
  endtask

  // advance one channel by one item; queues a window result when one closes
  task automatic track_window(input sample_item_t it);
    int s;
    longint rac, iac, rdc, idc, d;
    longint unsigned num, den, q;
    logic [CNT_W-1:0] wl;
    window_result_t res;
    s = int'(it.sel);
    if (s >= NUM_SENSORS) return;
    if (it.cmd == CMD_CLEAR) begin
      red_lo[s] = '0;
      red_hi[s] = '0;
      ir_lo[s] = '0;
      ir_hi[s] = '0;
      win_count[s] = '0;
      skip_left[s] = skip_load;
      return;
    end
    if (win_count[s] == 0) begin
      red_lo[s] = it.red;
      red_hi[s] = it.red;
      ir_lo[s] = it.ir;
      ir_hi[s] = it.ir;
    end else begin
      if (red_hi[s] < it.red) red_hi[s] = it.red;
      else if (red_lo[s] > it.red) red_lo[s] = it.red;
      if (ir_hi[s] < it.ir) ir_hi[s] = it.ir;
      else if (ir_lo[s] > it.ir) ir_lo[s] = it.ir;
    end
    if (skip_left[s] == 0) win_count[s] = win_count[s] + 1'b1;
    else skip_left[s] = skip_left[s] - 1'b1;
    wl = (win_len == 0) ? CNT_W'(1) : win_len;
    if (win_count[s] < wl) return;
    win_count[s] = '0;

    rac = longint'(red_hi[s]) - longint'(red_lo[s]);
    iac = longint'(ir_hi[s]) - longint'(ir_lo[s]);
    // signed division truncates toward zero
    rdc = (longint'(red_hi[s]) + longint'(red_lo[s])) / 2;
    idc = (longint'(ir_hi[s]) + longint'(ir_lo[s])) / 2;
    res.id = it.sel;
    res.spo2 = '0;
    res.rq = '0;
    res.err = 1'b0;
    if (rdc == 0 || idc == 0 || iac == 0) begin
      res.err = 1'b1;
    end else if (rac > 0 && ((rdc < 0) != (idc < 0))) begin
      res.err = 1'b1;
    end else begin
      num = longint'(rac) * longint'((idc < 0) ? -idc : idc);
      den = longint'((rdc < 0) ? -rdc : rdc) * longint'(iac);
      q = (num << FRAC_BITS) / den;
      if (q > 65535) q = 65535;
      res.rq = RQ_W'(q);
      d = (longint'(icpt_cal) <<< FRAC_BITS) - longint'(slope_cal) * longint'(q);
      if (d < 0) res.spo2 = '0;
      else if ((d >>> SPO2_SHIFT) > 255) res.spo2 = 8'd255;
      else res.spo2 = SPO2_W'(d >>> SPO2_SHIFT);
    end
    res.rac = mag_t'(rac);
    res.rdc = smp_t'(rdc);
    res.iac = mag_t'(iac);
    res.idc = smp_t'(idc);
    window_results.push_back(res);
  endtask

  // driver: presents queued items, each after its own idle gap
  sample_item_t on_port;
  int unsigned  gap_done = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_done = 0;
    end else begin
      if (in_valid && in_ready) begin
        track_window(on_port);
        items_taken++;
        if (on_port.cmd == CMD_CLEAR) clears_taken++;
      end
      if (!in_valid || in_ready) begin
        if (sample_fifo.size() != 0 && gap_done >= sample_fifo[0].gap) begin
          on_port = sample_fifo.pop_front();
          in_valid <= 1'b1;
          in_command <= on_port.cmd;
          in_sensor_select <= on_port.sel;
          in_red_sample <= on_port.red;
          in_ir_sample <= on_port.ir;
          gap_done = 0;
        end else begin
          in_valid <= 1'b0;
          if (sample_fifo.size() != 0) gap_done++;
        end
      end
    end
  end

  // monitor: takes results with random stalls, one long hold on request
  window_result_t want;
  int  stall_left = 0;
  int  press_seen = 0;
  bit  calm_rx = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (window_results.size() == 0) begin
          log_miss("result with nothing expected, sensor", '0, out_sensor_id);
        end else begin
          want = window_results.pop_front();
          if (out_sensor_id !== want.id) log_miss("sensor_id", want.id, out_sensor_id);
          if (out_spo2 !== want.spo2) log_miss("spo2", want.spo2, out_spo2);
          if (out_ratio_q12 !== want.rq) log_miss("ratio_q12", want.rq, out_ratio_q12);
          if (out_red_ac !== want.rac) log_miss("red_ac", want.rac, out_red_ac);
          if (out_red_dc !== want.rdc) log_miss("red_dc", want.rdc, out_red_dc);
          if (out_ir_ac !== want.iac) log_miss("ir_ac", want.iac, out_ir_ac);
          if (out_ir_dc !== want.idc) log_miss("ir_dc", want.idc, out_ir_dc);
          if (out_ratio_error !== want.err) begin
            log_miss("ratio_error", want.err, out_ratio_error);
          end
          if (want.err) flagged_seen++;
          if (want.rq == '1) sat_seen++;
        end
        windows_seen++;
        if (windows_seen % 50 == 0) calm_rx = !calm_rx;
        stall_left = calm_rx ? 0 : $urandom_range(0, 11);
      end
      if (press_token != press_seen) begin
        press_seen = press_token;
        stall_left = PRESS_HOLD;
      end
      if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("watchdog: %0d cycles with no accepted item", QUIET_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_WIN_LEN: win_len = val;
      REG_SKIP:    skip_load = val[SKIP_W-1:0];
      REG_SLOPE:   slope_cal = val;
      REG_ICPT:    icpt_cal = val;
      default: ;
    endcase
    reg_writes++;
  endtask

  // block is idle once nothing is queued or owed, plus the compute latency
  task automatic settle();
    do @(negedge clk);
    while (sample_fifo.size() != 0 || in_valid || window_results.size() != 0);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  function automatic int unsigned next_gap();
    queued_total++;
    return ((queued_total / 120) % 3 == 1) ? 0 : $urandom_range(0, 11);
  endfunction

  task automatic push_item(input logic cmd, input int sel, input int red, input int ir);
    sample_item_t it;
    it.cmd = cmd;
    it.sel = SEL_W'(sel);
    it.red = smp_t'(red);
    it.ir = smp_t'(ir);
    it.gap = next_gap();
    sample_fifo.push_back(it);
  endtask

  task automatic new_pulse(input int s);
    int mr, mi;
    mr = $urandom_range(64, 1500000);
    mi = $urandom_range(64, 1500000);
    dc_r[s] = ($urandom_range(0, 3) == 0) ? -mr : mr;
    // mostly matching signs, now and then opposite ones
    if ($urandom_range(0, 9) == 0) dc_i[s] = (dc_r[s] < 0) ? mi : -mi;
    else dc_i[s] = (dc_r[s] < 0) ? -mi : mi;
    amp_r[s] = $urandom_range(0, mr / 8);
    amp_i[s] = $urandom_range(1, mi / 8);
    pulse_left[s] = $urandom_range(10, 60);
  endtask

  function automatic int noise_value();
    case ($urandom_range(0, 7))
      0: return -2097152;
      1: return 2097151;
      2: return 0;
      3: return -1;
      default: return int'($urandom());
    endcase
  endfunction

  task automatic push_random(input int clr_pct, input int s0_pct);
    int s, roll;
    s = ($urandom_range(0, 99) < s0_pct) ? 0 : 1;
    roll = $urandom_range(0, 99);
    if (roll < clr_pct) begin
      push_item(CMD_CLEAR, s, int'($urandom()), int'($urandom()));
      new_pulse(s);
    end else if (roll < clr_pct + 10) begin
      push_item(CMD_SAMPLE, s, noise_value(), noise_value());
    end else begin
      if (pulse_left[s] <= 0) new_pulse(s);
      pulse_left[s]--;
      push_item(CMD_SAMPLE, s, dc_r[s] + int'($urandom_range(0, amp_r[s])),
                dc_i[s] + int'($urandom_range(0, amp_i[s])));
    end
  endtask

  initial begin
    int win, skp, slp, icp, n_items, clr_pct, s0_pct;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    for (int s = 0; s < NUM_SENSORS; s++) new_pulse(s);
    for (int p = 0; p < N_PHASES; p++) begin
      settle();
      case (p)
        0: begin
          win = 2; skp = 0; slp = SLOPE_RST; icp = ICPT_RST;
          n_items = 0; clr_pct = 0; s0_pct = 50;
        end
        1: begin
          win = 1; skp = 0; slp = SLOPE_RST; icp = ICPT_RST;
          n_items = 60; clr_pct = 0; s0_pct = 50;
        end
        2: begin
          win = 4; skp = 3; slp = SLOPE_RST; icp = ICPT_RST;
          n_items = 330; clr_pct = 4; s0_pct = 50;
        end
        3: begin
          // zero window length acts as one; full skip on sensor 0
          win = 0; skp = 255; slp = 0; icp = 65535;
          n_items = 300; clr_pct = 0; s0_pct = 95;
        end
        4: begin
          win = 65535; skp = 0; slp = 65535; icp = 0;
          n_items = 40; clr_pct = 0; s0_pct = 50;
        end
        5: begin
          // running counts exceed the new length: next sample closes the window
          win = 3; skp = 1; slp = $urandom_range(0, 65535); icp = $urandom_range(0, 65535);
          n_items = 300; clr_pct = 5; s0_pct = 50;
        end
        6: begin
          win = 16; skp = 8; slp = SLOPE_RST; icp = ICPT_RST;
          n_items = 300; clr_pct = 3; s0_pct = 50;
        end
        default: begin
          win = 9; skp = 2; slp = $urandom_range(0, 65535); icp = $urandom_range(0, 65535);
          n_items = 100; clr_pct = 6; s0_pct = 40;
        end
      endcase
      write_reg(REG_WIN_LEN, CFG_DATA_W'(win));
      write_reg(REG_SKIP, CFG_DATA_W'(skp));
      write_reg(REG_SLOPE, CFG_DATA_W'(slp));
      write_reg(REG_ICPT, CFG_DATA_W'(icp));
      @(negedge clk);
      if (p == 0) begin
        push_item(CMD_CLEAR, 0, 0, 0);
        push_item(CMD_CLEAR, 1, -1, -1);
        // full-scale swing, dc sums to -1 and truncates to zero
        push_item(CMD_SAMPLE, 0, 2097151, 2097151);
        push_item(CMD_SAMPLE, 0, -2097152, -2097152);
        // channels interleaved: unity ratio on 1, opposite dc signs on 0
        push_item(CMD_SAMPLE, 1, 100, 200);
        push_item(CMD_SAMPLE, 0, 100, -200);
        push_item(CMD_SAMPLE, 1, 300, 600);
        push_item(CMD_SAMPLE, 0, 300, -600);
        // flat red gives a zero ratio without a flag
        push_item(CMD_SAMPLE, 1, 500, 500);
        push_item(CMD_SAMPLE, 1, 500, 700);
        // tiny red dc against large ir dc saturates the ratio
        push_item(CMD_SAMPLE, 0, -50, 10000);
        push_item(CMD_SAMPLE, 0, 100, 10100);
        // flat ir is a zero denominator
        push_item(CMD_SAMPLE, 1, 100, 300);
        push_item(CMD_SAMPLE, 1, 300, 300);
        // clear in the middle of a window
        push_item(CMD_SAMPLE, 0, 0, 0);
        push_item(CMD_CLEAR, 0, 2097151, -2097152);
        push_item(CMD_SAMPLE, 0, 7, 7);
        push_item(CMD_SAMPLE, 0, 9, 9);
        // both dc negative
        push_item(CMD_SAMPLE, 1, -1000, -2000);
        push_item(CMD_SAMPLE, 1, -3000, -6000);
        // rounding toward zero on odd negative sums
        push_item(CMD_SAMPLE, 0, -1, -1);
        push_item(CMD_SAMPLE, 0, 0, 1);
        push_item(CMD_SAMPLE, 1, -3, 5);
        push_item(CMD_SAMPLE, 1, 0, 6);
      end else begin
        if (p == PRESS_PHASE) press_token++;
        if (p == 3) push_item(CMD_CLEAR, 0, 0, 0);
        repeat (n_items) push_random(clr_pct, s0_pct);
      end
    end
    settle();
    $display("run covered %0d items (%0d clears) and %0d windows, %0d flagged, %0d saturated",
             items_taken, clears_taken, windows_seen, flagged_seen, sat_seen);
    $display("%0d register writes over %0d settings, %0d field mismatches",
             reg_writes, N_PHASES, miss_count);
    if (miss_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
